### rtl/gcl_pkg.sv
// ----------------------------------------------------------------------------
// gcl_pkg
// Shared types and character codes for the G-code line checker.
// ----------------------------------------------------------------------------
`default_nettype none

package gcl_pkg;

    localparam int CH_W   = 8;
    localparam int NUM_W  = 32;
    localparam int STAT_W = 3;

    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CH_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CH_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [CH_W-1:0] CH_N     = 8'h4E;
    localparam logic [CH_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

    // Number parser phase after a key character
    typedef enum logic [1:0] {
        PH_SIGN   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2
    } t_phase;

    // Line verdict codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK_PLAIN    = 3'd0,
        ST_OK_NUMBERED = 3'd1,
        ST_BAD_LINE    = 3'd2,
        ST_BAD_SUM     = 3'd3,
        ST_NO_SUM      = 3'd4
    } t_status;

    // One verdict leaving the line controller
    typedef struct packed {
        logic                    valid;
        t_status                 status;
        logic [NUM_W-1:0]        last_line;
    } t_result;

endpackage

`default_nettype wire

### rtl/gcl_num_parser.sv
// ----------------------------------------------------------------------------
// gcl_num_parser
// Decimal number after a key: optional minus, digits, wraps at 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module gcl_num_parser (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_clear,
    input  wire logic                      i_en,
    input  wire logic [gcl_pkg::CH_W-1:0]  i_ch,
    output logic      [gcl_pkg::NUM_W-1:0] o_value
);
    import gcl_pkg::*;

    t_phase             r_phase, n_phase;
    logic               r_neg, n_neg;
    logic [NUM_W-1:0]   r_val, n_val;
    logic               is_digit;
    logic [NUM_W-1:0]   digit;

    assign is_digit = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    assign digit    = {{(NUM_W-CH_W){1'b0}}, i_ch - CH_ZERO};

    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_val   = r_val;
        if (i_clear) begin
            n_phase = PH_SIGN;
            n_neg   = 1'b0;
            n_val   = '0;
        end else if (i_en && (r_phase != PH_DONE)) begin
            priority if (is_digit) begin
                // times ten as two shifts and an add
                n_val   = (r_val << 3) + (r_val << 1) + digit;
                n_phase = PH_DIGITS;
            end else if ((r_phase == PH_SIGN) && (i_ch == CH_MINUS)) begin
                n_neg   = 1'b1;
                n_phase = PH_DIGITS;
            end else begin
                n_phase = PH_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIGN;
            r_neg   <= 1'b0;
            r_val   <= '0;
        end else begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_val   <= n_val;
        end
    end

    assign o_value = r_neg ? (NUM_W'(0) - r_val) : r_val;

endmodule

`default_nettype wire

### rtl/gcl_line_ctrl.sv
// ----------------------------------------------------------------------------
// gcl_line_ctrl
// Line framing, comment drop, checksum XOR and line verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module gcl_line_ctrl (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_adv,
    input  wire logic [gcl_pkg::CH_W-1:0] i_ch,
    output gcl_pkg::t_result              o_res
);
    import gcl_pkg::*;

    logic               r_in_comment, n_in_comment;
    logic               r_nonempty, n_nonempty;
    logic               r_seen_n, n_seen_n;
    logic               r_seen_star, n_seen_star;
    logic [CH_W-1:0]    r_xor, n_xor;
    logic [NUM_W-1:0]   r_last_good, n_last_good;

    logic               is_end, kept, clr;
    logic [NUM_W-1:0]   num_value, star_value;
    t_status            status;

    assign is_end = (i_ch == CH_CR) || (i_ch == CH_LF) ||
                    ((i_ch == CH_COLON) && !r_in_comment);
    assign kept   = !is_end && !r_in_comment && (i_ch != CH_SEMI);
    assign clr    = i_adv && is_end;

    gcl_num_parser u_num (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (clr),
        .i_en    (i_adv && kept && r_seen_n),
        .i_ch    (i_ch),
        .o_value (num_value)
    );

    gcl_num_parser u_star (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (clr),
        .i_en    (i_adv && kept && r_seen_star),
        .i_ch    (i_ch),
        .o_value (star_value)
    );

    always_comb begin
        priority if (!r_seen_n) begin
            status = ST_OK_PLAIN;
        end else if (num_value != (r_last_good + NUM_W'(1))) begin
            status = ST_BAD_LINE;
        end else if (!r_seen_star) begin
            status = ST_NO_SUM;
        end else if (star_value != {{(NUM_W-CH_W){1'b0}}, r_xor}) begin
            status = ST_BAD_SUM;
        end else begin
            status = ST_OK_NUMBERED;
        end
    end

    always_comb begin
        n_in_comment = r_in_comment;
        n_nonempty   = r_nonempty;
        n_seen_n     = r_seen_n;
        n_seen_star  = r_seen_star;
        n_xor        = r_xor;
        n_last_good  = r_last_good;
        if (is_end) begin
            n_in_comment = 1'b0;
            n_nonempty   = 1'b0;
            n_seen_n     = 1'b0;
            n_seen_star  = 1'b0;
            n_xor        = '0;
            if (r_nonempty && (status == ST_OK_NUMBERED)) begin
                n_last_good = r_last_good + NUM_W'(1);
            end
        end else if (kept) begin
            n_nonempty = 1'b1;
            if (!r_seen_star) begin
                if (i_ch == CH_STAR) begin
                    n_seen_star = 1'b1;
                end else begin
                    n_xor = r_xor ^ i_ch;
                end
            end
            if (i_ch == CH_N) begin
                n_seen_n = 1'b1;
            end
        end else if (i_ch == CH_SEMI) begin
            n_in_comment = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_comment <= 1'b0;
            r_nonempty   <= 1'b0;
            r_seen_n     <= 1'b0;
            r_seen_star  <= 1'b0;
            r_xor        <= '0;
            r_last_good  <= '0;
        end else if (i_adv) begin
            r_in_comment <= n_in_comment;
            r_nonempty   <= n_nonempty;
            r_seen_n     <= n_seen_n;
            r_seen_star  <= n_seen_star;
            r_xor        <= n_xor;
            r_last_good  <= n_last_good;
        end
    end

    assign o_res.valid     = is_end && r_nonempty;
    assign o_res.status    = status;
    assign o_res.last_line = n_last_good;

endmodule

`default_nettype wire

### rtl/gcode_line_checker_top.sv
// ----------------------------------------------------------------------------
// gcode_line_checker_top
// Checks G-code lines for line number sequence and XOR checksum.
// ----------------------------------------------------------------------------
//  channel   dir  tdata bits                         meaning
//  s_axis    in   [7:0] ch                           one received character
//  m_axis    out  [2:0] status, [34:3] last_line     one verdict per line
//
//  One character per cycle while the verdict path is not stalled; the
//  per-character update is a multiply-by-ten accumulate in each number parser.
//  A verdict follows the acceptance of its line end: the character waits
//  in the input register, then the verdict register loads.
//  Reset (synchronous, active low) clears all line state and the counter.
//  A stalled output holds the verdict; the input register keeps taking items
//  while it is empty or the output register is free or being drained this cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gcode_line_checker_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave side: [7:0] ch
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,
    // master side: [2:0] status, [34:3] last_line, [39:35] zero
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [39:0]      o_m_tdata
);
    import gcl_pkg::*;

    localparam int OUT_W = STAT_W + NUM_W;

    logic               r_in_valid;
    logic [CH_W-1:0]    r_in_ch;
    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_data;
    logic               out_free, adv;
    t_result            res;

    // Advance the held item whenever the result register can take a verdict
    assign out_free   = !r_out_valid || i_m_tready;
    assign adv        = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_ch <= i_s_tdata;
        end
    end

    gcl_line_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_ch    (r_in_ch),
        .o_res   (res)
    );

    // Result register: load a verdict on advance, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= res.valid;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && res.valid) begin
            r_out_data <= {res.last_line, res.status};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(40-OUT_W){1'b0}}, r_out_data};

    // Full input register behind a stalled verdict must block new items
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_m_tready) |-> !o_s_tready)
        else $error("input taken while pipeline stalled");

    // Delivered verdict code is always a defined one
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[2:0] <= 3'd4))
        else $error("undefined verdict code");

    // A numbered accept advances the counter by exactly one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && res.valid && (res.status == ST_OK_NUMBERED)) |=>
        (r_out_data[OUT_W-1:STAT_W] == $past(u_ctrl.r_last_good) + NUM_W'(1)))
        else $error("line counter step");

    // Nothing is offered right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

`default_nettype wire

### tb/sv/tb_gcode_line_checker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gcode_line_checker_top
// Self-checking bench for the G-code line checker. A short directed set of
// lines comes first, then random lines, most of them well formed with the
// right line number and XOR checksum, mixed with broken lines, comments and
// raw noise. Every accepted character runs through a line predictor, and
// each verdict on the output stream is compared with the oldest prediction.
// ----------------------------------------------------------------------------

module tb_gcode_line_checker_top;

    import gcl_pkg::*;

    localparam int N_ITEMS     = 1800;   // stop adding random lines past this
    localparam int QUIET_TAIL  = 200;    // last items run without idling
    localparam int HOLD_AT     = 600;    // item count that starts the long stall
    localparam int HOLD_LEN    = 80;     // cycles the receiver holds off
    localparam int DRAIN       = 10;     // cycles to catch stray verdicts
    localparam int CYCLE_LIMIT = 200000;

    // Parser of the number after an 'N' or a '*'
    typedef struct packed {
        t_phase      ph;
        logic        neg;
        logic [31:0] val;
    } t_num;

    // Per-line parse state plus the line counter
    typedef struct packed {
        logic        in_comment;
        logic        line_nonempty;
        logic        seen_n;
        t_num        num;
        logic        seen_star;
        t_num        sum;
        logic [7:0]  xr;
        logic [31:0] last_good;
    } t_line_state;

    typedef struct packed {
        t_status     status;
        logic [31:0] last_line;
    } t_verdict;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [7:0]  i_s_tdata  = 8'd0;   // [7:0] ch
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [39:0] o_m_tdata;           // [2:0] status, [34:3] last_line, [39:35] zero

    gcode_line_checker_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #10 i_clk = ~i_clk;

    logic [7:0]  pend_q[$];     // characters not yet accepted
    t_verdict    verdict_q[$];  // verdicts still to arrive
    logic [7:0]  line_buf[$];   // line under construction
    t_line_state track_st;      // follows the characters as they are accepted
    t_line_state gen_st;        // follows the characters as they are queued
    t_verdict    gen_dummy;
    t_verdict    got_v;
    t_verdict    want;
    logic        has_v;
    int          errors   = 0;
    int          cyc      = 0;
    int          n_sent   = 0;
    int          src_gap  = 0;
    int          snk_gap  = 0;
    int          hold_cnt = 0;
    logic        held     = 1'b0;
    logic        quiet    = 1'b0;

    // ------------------------------------------------------------------------
    // Line predictor
    // ------------------------------------------------------------------------
    function automatic t_line_state fresh_line(input logic [31:0] last_good);
        t_line_state s;
        s.in_comment    = 1'b0;
        s.line_nonempty = 1'b0;
        s.seen_n        = 1'b0;
        s.num.ph        = PH_SIGN;
        s.num.neg       = 1'b0;
        s.num.val       = 32'd0;
        s.seen_star     = 1'b0;
        s.sum.ph        = PH_SIGN;
        s.sum.neg       = 1'b0;
        s.sum.val       = 32'd0;
        s.xr            = 8'd0;
        s.last_good     = last_good;
        return s;
    endfunction

    function automatic t_num num_feed(input t_num p, input logic [7:0] c);
        t_num r;
        r = p;
        if (p.ph != PH_DONE) begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
                r.val = p.val * 32'd10 + {24'd0, c - CH_ZERO};
                r.ph  = PH_DIGITS;
            end else if (p.ph == PH_SIGN && c == CH_MINUS) begin
                r.neg = 1'b1;
                r.ph  = PH_DIGITS;
            end else begin
                r.ph = PH_DONE;
            end
        end
        return r;
    endfunction

    // Advance the line state by one character; returns 1 when a verdict is due
    function automatic logic line_step(inout t_line_state st, input logic [7:0] c,
                                       output t_verdict vd);
        logic [31:0] n_signed;
        logic [31:0] s_signed;
        logic        due;
        due          = 1'b0;
        vd.status    = ST_OK_PLAIN;
        vd.last_line = st.last_good;
        if (c == CH_CR || c == CH_LF || (c == CH_COLON && !st.in_comment)) begin
            if (st.line_nonempty) begin
                due      = 1'b1;
                n_signed = st.num.neg ? (32'd0 - st.num.val) : st.num.val;
                s_signed = st.sum.neg ? (32'd0 - st.sum.val) : st.sum.val;
                if (!st.seen_n)
                    vd.status = ST_OK_PLAIN;
                else if (n_signed != st.last_good + 32'd1)
                    vd.status = ST_BAD_LINE;
                else if (!st.seen_star)
                    vd.status = ST_NO_SUM;
                else if (s_signed != {24'd0, st.xr})
                    vd.status = ST_BAD_SUM;
                else begin
                    vd.status    = ST_OK_NUMBERED;
                    st.last_good = st.last_good + 32'd1;
                end
                vd.last_line = st.last_good;
            end
            // line end always leaves comment mode
            st = fresh_line(st.last_good);
        end else begin
            if (c == CH_SEMI)
                st.in_comment = 1'b1;
            if (!st.in_comment) begin
                st.line_nonempty = 1'b1;
                // parsers only see characters after their key
                if (st.seen_n)
                    st.num = num_feed(st.num, c);
                if (st.seen_star)
                    st.sum = num_feed(st.sum, c);
                if (!st.seen_star) begin
                    if (c == CH_STAR)
                        st.seen_star = 1'b1;
                    else
                        st.xr = st.xr ^ c;
                end
                if (!st.seen_n && c == CH_N)
                    st.seen_n = 1'b1;
            end
        end
        return due;
    endfunction

    // ------------------------------------------------------------------------
    // Line building
    // ------------------------------------------------------------------------
    task automatic add_byte(input logic [7:0] b);
        line_buf.push_back(b);
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    // Move the finished line to the pending queue, tracking the counter
    task automatic flush_line();
        foreach (line_buf[i]) begin
            pend_q.push_back(line_buf[i]);
            void'(line_step(gen_st, line_buf[i], gen_dummy));
        end
        line_buf.delete();
    endtask

    // Line text without terminators, comment starts or stars
    task automatic add_body(input int n);
        string      gc;
        logic [7:0] b;
        gc = "GXYZEFM0123456789.- ";
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) < 6) begin
                b = gc[$urandom_range(0, gc.len() - 1)];
            end else begin
                do b = 8'($urandom_range(0, 255));
                while (b == CH_CR || b == CH_LF || b == CH_COLON ||
                       b == CH_SEMI || b == CH_STAR);
            end
            add_byte(b);
        end
    endtask

    task automatic add_comment();
        logic [7:0] b;
        add_byte(CH_SEMI);
        repeat ($urandom_range(0, 6)) begin
            do b = 8'($urandom_range(0, 255));
            while (b == CH_CR || b == CH_LF);
            add_byte(b);
        end
    endtask

    task automatic add_random_line();
        int          kind;
        int          dly;
        logic [31:0] nxt;
        logic [63:0] big;
        logic [7:0]  cs;
        logic        commented;
        kind      = $urandom_range(0, 99);
        nxt       = gen_st.last_good + 32'd1;
        commented = 1'b0;
        if (kind < 75) begin
            // line number field
            if (kind >= 50 && kind < 58) begin
                dly = $urandom_range(0, 20);
                if (dly == 0)
                    add_str($sformatf("N%0d", nxt - 32'd1));
                else if (dly == 1)
                    add_str("N");
                else if (dly == 2)
                    add_str($sformatf("N-%0d", nxt));
                else
                    add_str($sformatf("N%0d", nxt + 32'(dly)));
            end else if (kind >= 70) begin
                // same number after 32-bit wrap, or as a negated magnitude
                if ($urandom_range(0, 1)) begin
                    big = {32'd0, nxt} + 64'h1_0000_0000 * 64'($urandom_range(1, 5));
                    add_str($sformatf("N%0d", big));
                end else begin
                    big = 64'h1_0000_0000 - {32'd0, nxt};
                    add_str($sformatf("N-%0d", big));
                end
            end else if ($urandom_range(0, 3) == 0) begin
                add_str($sformatf("N0%0d", nxt));
            end else begin
                add_str($sformatf("N%0d", nxt));
            end
            add_byte($urandom_range(0, 3) == 0 ? 8'h47 : CH_SPACE);
            add_body($urandom_range(0, 8));
            // checksum field
            if (kind < 58 || kind >= 64) begin
                cs = 8'd0;
                foreach (line_buf[i])
                    cs = cs ^ line_buf[i];
                add_byte(CH_STAR);
                if (kind >= 64 && kind < 70) begin
                    if ($urandom_range(0, 1))
                        add_str($sformatf("-%0d", (cs == 8'd0) ? 8'd1 : cs));
                    else
                        add_str($sformatf("%0d", cs ^ (8'd1 << $urandom_range(0, 7))));
                end else begin
                    add_str($sformatf("%0d", cs));
                end
            end
            if ($urandom_range(0, 4) == 0) begin
                add_byte(CH_SPACE);
                add_comment();
                commented = 1'b1;
            end
        end else if (kind < 85) begin
            add_body($urandom_range(1, 10));
            if ($urandom_range(0, 2) == 0)
                add_str($sformatf("*%0d", $urandom_range(0, 255)));
        end else if (kind < 90) begin
            if ($urandom_range(0, 1)) begin
                add_comment();
                commented = 1'b1;
            end
        end else begin
            repeat ($urandom_range(1, 12))
                add_byte(8'($urandom_range(0, 255)));
        end
        // terminator; a colon would not end a comment
        case ($urandom_range(commented ? 1 : 0, 3))
            0: add_byte(CH_COLON);
            1: add_byte(CH_CR);
            2: begin
                add_byte(CH_CR);
                add_byte(CH_LF);
            end
            default: add_byte(CH_LF);
        endcase
        flush_line();
    endtask

    // ------------------------------------------------------------------------
    // Driver: offer pending characters, predict each one as it is accepted
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= 8'd0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                has_v = line_step(track_st, i_s_tdata, got_v);
                if (has_v)
                    verdict_q.push_back(got_v);
                pend_q.delete(0);
                n_sent <= n_sent + 1;
            end
            if (i_s_tvalid && !o_s_tready) begin
                // hold the offered item
            end else if (src_gap > 0) begin
                src_gap    <= src_gap - 1;
                i_s_tvalid <= 1'b0;
            end else if (pend_q.size() == 0) begin
                i_s_tvalid <= 1'b0;
            end else if (!quiet && hold_cnt == 0 && (cyc / 256) % 4 != 3 &&
                         $urandom_range(0, 7) == 0) begin
                // idle burst
                src_gap    <= $urandom_range(0, 2);
                i_s_tvalid <= 1'b0;
            end else begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= pend_q[0];
            end
            quiet <= (pend_q.size() < QUIET_TAIL);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each verdict, drive the receiver's ready
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (verdict_q.size() == 0) begin
                    errors++;
                    $display("%0t: verdict with none expected, expected none actual %h",
                             $time, o_m_tdata);
                end else begin
                    want = verdict_q.pop_front();
                    if (o_m_tdata[2:0] !== want.status) begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, o_m_tdata[2:0]);
                    end
                    if (o_m_tdata[34:3] !== want.last_line) begin
                        errors++;
                        $display("%0t: last_line expected %0d actual %0d",
                                 $time, $signed(want.last_line), $signed(o_m_tdata[34:3]));
                    end
                    if (o_m_tdata[39:35] !== 5'd0) begin
                        errors++;
                        $display("%0t: pad bits expected 0 actual %b",
                                 $time, o_m_tdata[39:35]);
                    end
                end
            end
            if (!held && n_sent >= HOLD_AT) begin
                // long hold-off: the sender keeps offering until the block stalls
                held       <= 1'b1;
                hold_cnt   <= HOLD_LEN;
                i_m_tready <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt   <= hold_cnt - 1;
                i_m_tready <= 1'b0;
            end else if (snk_gap > 0) begin
                snk_gap    <= snk_gap - 1;
                i_m_tready <= 1'b0;
            end else if (!quiet && (cyc / 256) % 4 != 1 && $urandom_range(0, 7) == 0) begin
                snk_gap    <= $urandom_range(0, 2);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("tb_gcode_line_checker_top: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        track_st = fresh_line(32'd0);
        gen_st   = fresh_line(32'd0);

        // good numbered line, checksum of "N1"
        add_str("N1*127");
        add_byte(CH_LF);
        // empty line
        add_byte(CH_LF);
        // comment-only line, colon inside the comment does not end it
        add_str(";c:");
        add_byte(CH_LF);
        // unnumbered line ended by a colon
        add_str("G:");
        // wrong line number
        add_str("N5");
        add_byte(CH_CR);
        // checksum missing
        add_str("N2");
        add_byte(CH_LF);
        // checksum wrong
        add_str("N2*0");
        add_byte(CH_LF);
        // byte extremes are ordinary line bytes
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(CH_LF);
        flush_line();

        while (pend_q.size() < N_ITEMS)
            add_random_line();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pend_q.size() != 0 || verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (errors == 0)
            $display("tb_gcode_line_checker_top: PASS");
        else
            $display("tb_gcode_line_checker_top: FAIL");
        $finish;
    end

endmodule

### filelist.f
rtl/gcl_pkg.sv
rtl/gcl_num_parser.sv
rtl/gcl_line_ctrl.sv
rtl/gcode_line_checker_top.sv
tb/sv/tb_gcode_line_checker_top.sv
